// ----- design/pftd_pkg.sv -----
// ============================================================================
// pftd_pkg
// Shared constants, types and state encoding for the trial-division
// prime filter.
// ============================================================================
package pftd_pkg;

    localparam int VALUE_BITS = 16;
    localparam int LIST_DEPTH = 32;

    localparam int MAG_BITS   = VALUE_BITS - 1;
    localparam int SQ_BITS    = VALUE_BITS + 1;
    localparam int STEP_BITS  = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;
    localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int PRIME_BITS = 15;
    localparam int POS_BITS   = 5;

    localparam int SMALLEST_PRIME = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_status;

endpackage

// ----- design/pftd_if.sv -----
// ============================================================================
// pftd interfaces
// Valid/ready channels for test requests and prime results.
// ============================================================================
interface pftd_in_if;
    import pftd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  starts_list;

    modport source (output valid, value, starts_list, input ready);
    modport sink   (input valid, value, starts_list, output ready);
endinterface

interface pftd_out_if;
    import pftd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PRIME_BITS-1:0] prime_value;
    logic [POS_BITS-1:0]   position;
    logic                  overflow;

    modport source (output valid, prime_value, position, overflow, input ready);
    modport sink   (input valid, prime_value, position, overflow, output ready);
endinterface

// ----- design/pftd_mod_unit.sv -----
// ============================================================================
// pftd_mod_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle,
// reports whether the remainder is zero.
// ============================================================================
module pftd_mod_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pftd_pkg::MAG_BITS-1:0] i_dividend,
    input  logic [pftd_pkg::MAG_BITS-1:0] i_divisor,
    output pftd_pkg::t_mod_status        o_status
);
    import pftd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [MAG_BITS-1:0]  r_rem;
    logic [MAG_BITS-1:0]  r_dvd;
    logic [MAG_BITS-1:0]  r_div;

    logic [MAG_BITS:0]    rem_sh;
    logic [MAG_BITS:0]    div_ext;
    logic [MAG_BITS-1:0]  n_rem;
    logic                 last_step;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[MAG_BITS-1]};
        div_ext = {1'b0, r_div};
        if (rem_sh >= div_ext) begin
            n_rem = MAG_BITS'(rem_sh - div_ext);
        end else begin
            n_rem = MAG_BITS'(rem_sh);
        end
        last_step = (r_cnt == STEP_BITS'(MAG_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_BITS'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

// ----- design/prime_filter_trial_division.sv -----
// ============================================================================
// prime_filter_trial_division
// Trial-division primality filter with a compacted output list index.
// ============================================================================
// Each request is tested by dividing by 2, 3, 4, ... while the divisor
// squared does not exceed the value; one shared bit-serial remainder unit
// does every trial. A trial is a compare-and-start step, MAG_BITS remainder
// steps and a result step. A request that is negative or below two is taken
// in the idle state and dropped without a trial. Input is not ready while a
// test is in progress; a found prime sits in an output register, so the
// next request is taken while that result waits.
module prime_filter_trial_division (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pftd_in_if.sink      i_in,
    pftd_out_if.source   o_out
);
    import pftd_pkg::*;

    t_state                r_state;
    t_state                n_state;

    logic [MAG_BITS-1:0]   r_val;
    logic [MAG_BITS-1:0]   r_d;
    logic [SQ_BITS-1:0]    r_sq;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_out_valid;
    logic [PRIME_BITS-1:0] r_out_prime;
    logic [POS_BITS-1:0]   r_out_pos;
    logic                  r_out_ovf;

    logic [MAG_BITS-1:0]   in_mag;
    logic                  in_reject;
    logic                  accept;
    logic                  sq_over;
    logic                  div_start;
    logic                  emit;
    logic                  slot_free;
    logic                  list_full;
    t_mod_status           mod_status;

    pftd_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_val),
        .i_divisor  (r_d),
        .o_status   (mod_status)
    );

    assign in_mag    = i_in.value[MAG_BITS-1:0];
    assign in_reject = i_in.value[VALUE_BITS-1] || (in_mag < MAG_BITS'(SMALLEST_PRIME));
    assign accept    = i_in.valid && i_in.ready;
    assign sq_over   = (r_sq > SQ_BITS'(r_val));
    assign slot_free = !r_out_valid || o_out.ready;
    assign list_full = (r_count == COUNT_BITS'(LIST_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid && !in_reject) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sq_over) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (mod_status.done) begin
                    n_state = mod_status.rem_zero ? S_IDLE : S_CHECK;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_CHECK: div_start  = !sq_over;
            S_DIV:   ;
            S_EMIT:  emit       = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // clear the list index at a list-start request, then advance on each kept prime until the list is full
            if (accept && i_in.starts_list) begin
                r_count <= '0;
            end else if (emit && !list_full) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= in_mag;
            r_d   <= MAG_BITS'(SMALLEST_PRIME);
            r_sq  <= SQ_BITS'(SMALLEST_PRIME * SMALLEST_PRIME);
        end else if ((r_state == S_DIV) && mod_status.done) begin
            // (d+1)^2 = d^2 + 2d + 1
            r_d  <= r_d + MAG_BITS'(1);
            r_sq <= r_sq + SQ_BITS'({r_d, 1'b1});
        end
        if (emit) begin
            r_out_prime <= PRIME_BITS'(r_val);
            r_out_ovf   <= list_full;
            if (list_full) begin
                r_out_pos <= POS_BITS'(LIST_DEPTH - 1);
            end else begin
                r_out_pos <= POS_BITS'(r_count);
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.prime_value = r_out_prime;
    assign o_out.position    = r_out_pos;
    assign o_out.overflow    = r_out_ovf;

endmodule

// ----- verif/tb_prime_filter_trial_division.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_prime_filter_trial_division
// Self-checking bench: directed edge values, then random requests over four
// handshake pressure phases. A local primality predictor tracks the list
// position and overflow flag and checks every result in order.
// ============================================================================
module tb_prime_filter_trial_division;
    import pftd_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  starts_list;
    } t_req;

    typedef struct packed {
        logic [PRIME_BITS-1:0] prime_value;
        logic [POS_BITS-1:0]   position;
        logic                  overflow;
    } t_prime;

    logic i_clk;
    logic i_rst_n;

    pftd_in_if  in_if ();
    pftd_out_if out_if ();

    prime_filter_trial_division u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_req   test_queue[$];
    t_prime expected_primes[$];
    int     list_fill;
    int     err_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic   req_taken;

    function automatic bit prime_by_division(int unsigned v);
        int unsigned d;
        if (v < 2)
            return 1'b0;
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Predict the result of one accepted request and queue it
    function automatic void predict_prime(t_req req);
        t_prime res;
        if (req.starts_list)
            list_fill = 0;
        if (req.value[VALUE_BITS-1] || !prime_by_division(int'(req.value)))
            return;
        res.prime_value = req.value[PRIME_BITS-1:0];
        if (list_fill < LIST_DEPTH) begin
            res.position = list_fill[POS_BITS-1:0];
            res.overflow = 1'b0;
            list_fill++;
        end else begin
            res.position = POS_BITS'(LIST_DEPTH - 1);
            res.overflow = 1'b1;
        end
        expected_primes.push_back(res);
    endfunction

    function automatic int unsigned pick_prime(int unsigned lo, int unsigned hi);
        int unsigned v;
        v = $urandom_range(hi, lo);
        while (!prime_by_division(v))
            v = $urandom_range(hi, lo);
        return v;
    endfunction

    function automatic void add_req(logic [VALUE_BITS-1:0] value, logic starts_list);
        t_req req;
        req.value       = value;
        req.starts_list = starts_list;
        test_queue.push_back(req);
    endfunction

    function automatic void queue_random(int n);
        int r;
        logic [VALUE_BITS-1:0] v;
        logic start;
        for (int k = 0; k < n; k++) begin
            r     = $urandom_range(99);
            start = ($urandom_range(39) == 0);
            if (r < 40)
                v = VALUE_BITS'(pick_prime(2, 1000));
            else if (r < 45)
                v = VALUE_BITS'(pick_prime(1000, 32767));
            else if (r < 65)
                v = VALUE_BITS'($urandom_range(300));
            else if (r < 80)
                v = VALUE_BITS'($urandom());
            else if (r < 90)
                v = VALUE_BITS'($urandom() | (1 << (VALUE_BITS - 1)));
            else
                v = VALUE_BITS'(pick_prime(2, 180) * pick_prime(2, 180));
            add_req(v, start);
        end
    endfunction

    // Start a fresh list and keep adding primes, with some negative or even values mixed in
    function automatic void queue_list_run(int n);
        add_req(VALUE_BITS'(pick_prime(2, 400)), 1'b1);
        for (int k = 1; k < n; k++) begin
            if ($urandom_range(3) == 0)
                add_req(($urandom_range(1) != 0) ? VALUE_BITS'($urandom()) | 16'h8000
                                                 : VALUE_BITS'($urandom_range(500) * 2), 1'b0);
            add_req(VALUE_BITS'(pick_prime(2, 400)), 1'b0);
        end
    endfunction

    task automatic drain;
        while (test_queue.size() != 0 || in_if.valid || expected_primes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Driver: advance to the next request once the current one is taken
    always @(negedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || req_taken) begin
            if (test_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = test_queue.pop_front();
                in_if.valid       <= 1'b1;
                in_if.value       <= nxt.value;
                in_if.starts_list <= nxt.starts_list;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_req req;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            req.value       = in_if.value;
            req.starts_list = in_if.starts_list;
            predict_prime(req);
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_prime got;
        t_prime exp_res;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.prime_value = out_if.prime_value;
            got.position    = out_if.position;
            got.overflow    = out_if.overflow;
            if (expected_primes.size() == 0) begin
                $display("%0t: unexpected result value=%0d pos=%0d ovf=%0b", $time,
                         got.prime_value, got.position, got.overflow);
                err_count++;
            end else begin
                exp_res = expected_primes.pop_front();
                if (got !== exp_res) begin
                    $display("%0t: mismatch expected value=%0d pos=%0d ovf=%0b, got value=%0d pos=%0d ovf=%0b",
                             $time, exp_res.prime_value, exp_res.position, exp_res.overflow,
                             got.prime_value, got.position, got.overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_prime_filter_trial_division: FAIL");
        $finish;
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.value       = '0;
        in_if.starts_list = 1'b0;
        out_if.ready      = 1'b0;
        req_taken         = 1'b0;
        list_fill         = 0;
        err_count         = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        i_rst_n           = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: below two, negatives, squares at the divisor bound,
        // largest values, and start of list with prime and non-prime
        add_req(16'd0, 1'b1);
        add_req(16'd1, 1'b0);
        add_req(16'd2, 1'b0);
        add_req(16'd3, 1'b0);
        add_req(16'd4, 1'b0);
        add_req(16'd9, 1'b0);
        add_req(16'd25, 1'b0);
        add_req(16'hFFFF, 1'b0);
        add_req(16'h8000, 1'b0);
        add_req(16'hFFFE, 1'b0);
        add_req(16'd32767, 1'b0);
        add_req(16'd32749, 1'b0);
        add_req(16'd32761, 1'b0);
        add_req(16'd5, 1'b1);
        add_req(16'd7, 1'b0);
        add_req(16'd0, 1'b1);
        add_req(16'd11, 1'b0);
        add_req(16'h7FFE, 1'b0);
        add_req(16'h4001, 1'b0);
        add_req(16'd2, 1'b1);
        queue_random(20);
        drain();

        // Hold off the sender until every result is back, then switch pressure
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        queue_list_run(36);
        queue_random(8);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        queue_random(40);
        drain();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        queue_list_run(34);
        queue_random(10);
        drain();

        // Let any trailing test finish so a stray result would show up
        repeat (4000) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_prime_filter_trial_division: PASS");
        else
            $display("tb_prime_filter_trial_division: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/pftd_pkg.sv
design/pftd_if.sv
design/pftd_mod_unit.sv
design/prime_filter_trial_division.sv
verif/tb_prime_filter_trial_division.sv
